/* hdl/sis_pkg.sv */
`timescale 1ns / 1ps

package sis_pkg;

  localparam int OPD_W = 10;
  localparam int CNT_OUT_W = 11;
  localparam int UA_W = 3;

  // Commands
  localparam logic [2:0] CMD_INC_POS  = 3'd0;
  localparam logic [2:0] CMD_EXC_POS  = 3'd1;
  localparam logic [2:0] CMD_INC_ELEM = 3'd2;
  localparam logic [2:0] CMD_EXC_ELEM = 3'd3;
  localparam logic [2:0] CMD_QUERY    = 3'd4;

  // Result status
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_SAME  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Result kinds raised by a control word
  localparam logic [1:0] EM_NONE  = 2'd0;
  localparam logic [1:0] EM_MOVE  = 2'd1;
  localparam logic [1:0] EM_RANGE = 2'd2;
  localparam logic [1:0] EM_KEEP  = 2'd3;

  // Jump types
  localparam logic [1:0] JT_NEXT     = 2'd0;
  localparam logic [1:0] JT_DISPATCH = 2'd1;
  localparam logic [1:0] JT_KEEP     = 2'd2;

  // Microprogram addresses; the move sequence must follow the check step.
  localparam logic [UA_W-1:0] UA_START  = 3'd0;
  localparam logic [UA_W-1:0] UA_CHECK  = 3'd1;
  localparam logic [UA_W-1:0] UA_MOVE   = 3'd2;
  localparam logic [UA_W-1:0] UA_WRITE  = 3'd3;
  localparam logic [UA_W-1:0] UA_FINISH = 3'd4;
  localparam logic [UA_W-1:0] UA_RANGE  = 3'd5;
  localparam logic [UA_W-1:0] UA_KEEP   = 3'd6;

  typedef struct packed {
    logic [2:0]       command;
    logic [OPD_W-1:0] operand;
  } sis_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OPD_W-1:0]     moved_element;
    logic [OPD_W-1:0]     new_position;
    logic                 is_member;
    logic [CNT_OUT_W-1:0] included_count;
  } sis_out_t;

  typedef struct packed {
    logic            rd_where;
    logic            ld_pos;
    logic            rd_src;
    logic            wr_b;
    logic            wr_c;
    logic [1:0]      emit;
    logic            last;
    logic [1:0]      jt;
    logic [UA_W-1:0] tgt;
  } sis_ucw_t;

  typedef struct packed {
    logic bad;
    logic bypos;
    logic keep;
  } sis_cond_t;

  function automatic sis_ucw_t ucode_rom(input logic [UA_W-1:0] addr);
    sis_ucw_t w;
    w = '0;
    case (addr)
      UA_START: begin
        w.rd_where = 1'b1;
        w.jt       = JT_DISPATCH;
      end
      UA_CHECK: begin
        w.ld_pos = 1'b1;
        w.jt     = JT_KEEP;
        w.tgt    = UA_KEEP;
      end
      UA_MOVE: begin
        w.rd_src = 1'b1;
      end
      UA_WRITE: begin
        w.wr_b = 1'b1;
      end
      UA_FINISH: begin
        w.wr_c = 1'b1;
        w.emit = EM_MOVE;
        w.last = 1'b1;
      end
      UA_RANGE: begin
        w.emit = EM_RANGE;
        w.last = 1'b1;
      end
      UA_KEEP: begin
        w.emit = EM_KEEP;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/sis_seq.sv */
`timescale 1ns / 1ps

module sis_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  sis_pkg::sis_cond_t  cond,
  output sis_pkg::sis_ucw_t   ctl,
  output logic                run_busy
);
  import sis_pkg::*;

  logic [UA_W-1:0] upc_r, upc_nxt;
  logic            run_r, run_nxt;
  sis_ucw_t        cw;

  assign cw = ucode_rom(upc_r);
  assign ctl = run_r ? cw : '0;
  // The final step frees the block, so the next word can be taken at its edge.
  assign run_busy = run_r & ~cw.last;

  always_comb begin
    upc_nxt = upc_r;
    run_nxt = run_r;
    if (accept) begin
      run_nxt = 1'b1;
      upc_nxt = UA_START;
    end else if (run_r) begin
      if (cw.last) begin
        run_nxt = 1'b0;
      end else begin
        case (cw.jt)
          JT_NEXT: begin
            upc_nxt = upc_r + UA_W'(1);
          end
          JT_DISPATCH: begin
            if (cond.bad) begin
              upc_nxt = UA_RANGE;
            end else if (cond.bypos) begin
              upc_nxt = UA_MOVE;
            end else begin
              upc_nxt = upc_r + UA_W'(1);
            end
          end
          JT_KEEP: begin
            upc_nxt = cond.keep ? cw.tgt : upc_r + UA_W'(1);
          end
          default: begin
            upc_nxt = upc_r + UA_W'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      upc_r <= UA_START;
    end else begin
      run_r <= run_nxt;
      upc_r <= upc_nxt;
    end
  end

endmodule

/* hdl/sis_data.sv */
`timescale 1ns / 1ps

module sis_data #(
  parameter int UNIVERSE = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  sis_pkg::sis_in_t    in_item,
  input  sis_pkg::sis_ucw_t   ctl,
  output sis_pkg::sis_cond_t  cond,
  output logic                clearing,
  output logic                out_valid,
  output sis_pkg::sis_out_t   out_item
);
  import sis_pkg::*;

  localparam int IW   = $clog2(UNIVERSE);
  localparam int CW   = $clog2(UNIVERSE + 1);
  localparam int CMPW = (CW > OPD_W) ? CW : OPD_W;

  // List stores and one position map; the top bit of a map entry marks membership.
  logic [IW-1:0] inc_mem_r   [UNIVERSE];
  logic [IW-1:0] exc_mem_r   [UNIVERSE];
  logic [IW:0]   where_mem_r [UNIVERSE];

  logic          clr_r;
  logic [IW-1:0] clr_idx_r;
  logic [2:0]    cmd_r;
  logic [OPD_W-1:0] opd_r;
  logic [IW-1:0] pos_r;
  logic [CW-1:0] total_r, total_nxt;
  logic [IW:0]   where_rd_r;
  logic [IW-1:0] inc_a_r, inc_b_r, exc_a_r, exc_b_r;
  logic          out_valid_r;
  sis_out_t      out_item_r, out_nxt;

  logic [CW-1:0]   ex_cnt;
  logic [CMPW-1:0] opd_w;
  logic            dir_in;
  logic            where_mbr;
  logic [IW-1:0]   where_pos;
  logic [IW-1:0]   elem, last, dst_idx, last_addr;

  logic          inc_we, exc_we, where_we;
  logic [IW-1:0] inc_wa, inc_wd, exc_wa, exc_wd, where_wa;
  logic [IW:0]   where_wd;

  assign ex_cnt    = CW'(UNIVERSE) - total_r;
  assign opd_w     = CMPW'(opd_r);
  assign dir_in    = (cmd_r == CMD_INC_POS) || (cmd_r == CMD_INC_ELEM);
  assign where_mbr = where_rd_r[IW];
  assign where_pos = where_rd_r[IW-1:0];
  assign elem      = dir_in ? exc_a_r : inc_a_r;
  assign last      = dir_in ? exc_b_r : inc_b_r;
  assign dst_idx   = dir_in ? IW'(total_r) : IW'(ex_cnt);
  assign last_addr = dir_in ? IW'(ex_cnt - CW'(1)) : IW'(total_r - CW'(1));

  always_comb begin
    total_nxt = total_r;
    if (ctl.wr_c) begin
      total_nxt = dir_in ? total_r + CW'(1) : total_r - CW'(1);
    end
  end

  always_comb begin
    cond.bypos = cmd_r inside {CMD_INC_POS, CMD_EXC_POS};
    cond.keep  = (cmd_r == CMD_QUERY) ||
                 ((cmd_r == CMD_INC_ELEM) && where_mbr) ||
                 ((cmd_r == CMD_EXC_ELEM) && !where_mbr);
    case (cmd_r)
      CMD_INC_POS:  cond.bad = opd_w >= CMPW'(ex_cnt);
      CMD_EXC_POS:  cond.bad = opd_w >= CMPW'(total_r);
      CMD_INC_ELEM, CMD_EXC_ELEM, CMD_QUERY: begin
        cond.bad = opd_w >= CMPW'(UNIVERSE);
      end
      default:      cond.bad = 1'b1;
    endcase
  end

  // Swap-remove writes the last entry into the freed slot and appends the
  // moved element to the other list; its own map entry is written a step
  // later so that it wins when it was itself the last entry.
  always_comb begin
    exc_we = 1'b0;
    exc_wa = pos_r;
    exc_wd = last;
    inc_we = 1'b0;
    inc_wa = pos_r;
    inc_wd = last;
    where_we = 1'b0;
    where_wa = last;
    where_wd = {~dir_in, pos_r};
    if (clr_r) begin
      exc_we   = 1'b1;
      exc_wa   = clr_idx_r;
      exc_wd   = clr_idx_r;
      where_we = 1'b1;
      where_wa = clr_idx_r;
      where_wd = {1'b0, clr_idx_r};
    end else begin
      if (ctl.wr_b) begin
        exc_we   = 1'b1;
        inc_we   = 1'b1;
        where_we = 1'b1;
        if (dir_in) begin
          inc_wa = dst_idx;
          inc_wd = elem;
        end else begin
          exc_wa = dst_idx;
          exc_wd = elem;
        end
      end
      if (ctl.wr_c) begin
        where_we = 1'b1;
        where_wa = elem;
        where_wd = {dir_in, dst_idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inc_we) begin
      inc_mem_r[inc_wa] <= inc_wd;
    end
    if (ctl.rd_src) begin
      inc_a_r <= inc_mem_r[pos_r];
      inc_b_r <= inc_mem_r[last_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (exc_we) begin
      exc_mem_r[exc_wa] <= exc_wd;
    end
    if (ctl.rd_src) begin
      exc_a_r <= exc_mem_r[pos_r];
      exc_b_r <= exc_mem_r[last_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (where_we) begin
      where_mem_r[where_wa] <= where_wd;
    end
    if (ctl.rd_where) begin
      where_rd_r <= where_mem_r[IW'(opd_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      total_r   <= '0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + IW'(1);
        if (clr_idx_r == IW'(UNIVERSE - 1)) begin
          clr_r <= 1'b0;
        end
      end
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.command;
      opd_r <= in_item.operand;
      pos_r <= IW'(in_item.operand);
    end else if (ctl.ld_pos) begin
      pos_r <= where_pos;
    end
  end

  always_comb begin
    out_nxt = '0;
    out_nxt.included_count = CNT_OUT_W'(total_nxt);
    case (ctl.emit)
      EM_MOVE: begin
        out_nxt.status        = ST_DONE;
        out_nxt.moved_element = OPD_W'(elem);
        out_nxt.new_position  = OPD_W'(dst_idx);
        out_nxt.is_member     = dir_in;
      end
      EM_KEEP: begin
        out_nxt.status        = (cmd_r == CMD_QUERY) ? ST_DONE : ST_SAME;
        out_nxt.moved_element = opd_r;
        out_nxt.new_position  = OPD_W'(where_pos);
        out_nxt.is_member     = where_mbr;
      end
      EM_RANGE: begin
        out_nxt.status = ST_RANGE;
      end
      default: begin
        out_nxt.status = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit != EM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit != EM_NONE) begin
      out_item_r <= out_nxt;
    end
  end

  assign clearing  = clr_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/sparse_index_set.sv */
`timescale 1ns / 1ps

// Sparse index set: a command word is taken when start is high and busy is
// low, and its result word appears on out_item for exactly one cycle with
// out_valid high; the receiver cannot stall it. After reset the block is
// busy while it sweeps the excluded list and position map to identity.
// A microcoded sequencer runs each command on the list and map memories,
// and busy falls during the final step: start, move, write, finish for a
// move by position; start, check, move, write, finish by element; start,
// check, keep for a query or no change; start, range if out of range or
// unknown. The result is shown in the cycle after the last step.
module sparse_index_set #(
  parameter int UNIVERSE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sis_pkg::sis_in_t   in_item,
  output logic               out_valid,
  output sis_pkg::sis_out_t  out_item
);
  import sis_pkg::*;

  sis_ucw_t  ctl;
  sis_cond_t cond;
  logic      run_busy;
  logic      clearing;
  logic      accept;

  assign busy   = clearing | run_busy;
  assign accept = start & ~busy;

  sis_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cond     (cond),
    .ctl      (ctl),
    .run_busy (run_busy)
  );

  sis_data #(
    .UNIVERSE (UNIVERSE)
  ) u_data (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .ctl       (ctl),
    .cond      (cond),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* hdl/sis_check.sv */
`timescale 1ns / 1ps

module sis_check (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input sis_pkg::sis_out_t out_item
);
  import sis_pkg::*;

  // A taken command always makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low straight after a command was taken");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_DONE || out_item.status == ST_SAME ||
                   out_item.status == ST_RANGE))
    else $error("result word carries an unused status code");

  a_range_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_RANGE) |->
      (out_item.moved_element == '0 && out_item.new_position == '0 &&
       !out_item.is_member))
    else $error("out-of-range result with non-zero fields");

  // An included element means the included list cannot be empty.
  a_member_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_RANGE && out_item.is_member) |->
      out_item.included_count != '0)
    else $error("member reported with an empty included list");

endmodule

bind sparse_index_set sis_check u_sis_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import sis_pkg::*;

  localparam int UNIVERSE = 1024;
  localparam logic [10:0] NOWHERE = 11'd1024;
  // Two copies of the set state: one tracks the block as words are taken,
  // the other runs ahead while the stimulus is built.
  localparam int CHK = 0;
  localparam int GEN = 1;
  localparam int RANDOM_WORDS = 1000;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 12;
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    logic    drain;
    sis_in_t word;
  } queued_word_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  sis_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  sis_out_t out_item;

  sparse_index_set #(.UNIVERSE(UNIVERSE)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [9:0]  inc_list  [0:1][0:UNIVERSE-1];
  logic [10:0] inc_where [0:1][0:UNIVERSE-1];
  logic [9:0]  exc_list  [0:1][0:UNIVERSE-1];
  logic [10:0] exc_where [0:1][0:UNIVERSE-1];
  logic [10:0] inc_total [0:1];

  queued_word_t cmd_queue[$];
  sis_out_t     awaited[$];
  sis_out_t     want;
  logic         stim_on = 1'b0;
  logic         word_taken = 1'b0;
  int           n_queued = 0;
  int           n_taken = 0;
  int           n_errors = 0;
  int           n_done = 0;
  int           n_same = 0;
  int           n_range = 0;
  int           peak_count = 0;
  int           idle_cycles = 0;
  int           burst_left = 8;
  int           gap_left = 0;

  function automatic sis_out_t move_in(input int k, input logic [10:0] pos);
    sis_out_t    r;
    logic [9:0]  e;
    logic [9:0]  tail_e;
    logic [10:0] exc_n;
    logic [9:0]  src_p;
    logic [9:0]  tail_p;
    logic [9:0]  head_p;
    exc_n = 11'(UNIVERSE) - inc_total[k];
    src_p = pos[9:0];
    tail_p = 10'(exc_n - 11'd1);
    head_p = inc_total[k][9:0];
    e = exc_list[k][src_p];
    tail_e = exc_list[k][tail_p];
    exc_list[k][src_p] = tail_e;
    exc_where[k][tail_e] = pos;
    exc_where[k][e] = NOWHERE;
    inc_list[k][head_p] = e;
    inc_where[k][e] = inc_total[k];
    r = '0;
    r.status = ST_DONE;
    r.moved_element = e;
    r.new_position = inc_total[k][9:0];
    r.is_member = 1'b1;
    inc_total[k] = inc_total[k] + 11'd1;
    return r;
  endfunction

  function automatic sis_out_t move_out(input int k, input logic [10:0] pos);
    sis_out_t    r;
    logic [9:0]  e;
    logic [9:0]  tail_e;
    logic [10:0] exc_n;
    logic [9:0]  src_p;
    logic [9:0]  tail_p;
    logic [9:0]  dst_p;
    exc_n = 11'(UNIVERSE) - inc_total[k];
    src_p = pos[9:0];
    tail_p = 10'(inc_total[k] - 11'd1);
    dst_p = exc_n[9:0];
    e = inc_list[k][src_p];
    tail_e = inc_list[k][tail_p];
    inc_list[k][src_p] = tail_e;
    inc_where[k][tail_e] = pos;
    inc_where[k][e] = NOWHERE;
    exc_list[k][dst_p] = e;
    exc_where[k][e] = exc_n;
    inc_total[k] = inc_total[k] - 11'd1;
    r = '0;
    r.status = ST_DONE;
    r.moved_element = e;
    r.new_position = exc_n[9:0];
    r.is_member = 1'b0;
    return r;
  endfunction

  // Applies one command word to copy k of the set and returns its result.
  function automatic sis_out_t step_set(input int k, input sis_in_t w);
    sis_out_t r;
    logic     inc;
    r = '0;
    r.status = ST_RANGE;
    case (w.command)
      CMD_INC_POS: begin
        if (w.operand < UNIVERSE - inc_total[k]) r = move_in(k, {1'b0, w.operand});
      end
      CMD_EXC_POS: begin
        if (w.operand < inc_total[k]) r = move_out(k, {1'b0, w.operand});
      end
      CMD_INC_ELEM, CMD_EXC_ELEM, CMD_QUERY: begin
        if (w.operand < UNIVERSE) begin
          inc = (inc_where[k][w.operand] != NOWHERE);
          if (w.command == CMD_INC_ELEM && !inc) begin
            r = move_in(k, exc_where[k][w.operand]);
          end else if (w.command == CMD_EXC_ELEM && inc) begin
            r = move_out(k, inc_where[k][w.operand]);
          end else begin
            r.status = (w.command == CMD_QUERY) ? ST_DONE : ST_SAME;
            r.moved_element = w.operand;
            r.is_member = inc;
            r.new_position = inc ? inc_where[k][w.operand][9:0]
                                 : exc_where[k][w.operand][9:0];
          end
        end
      end
      default: begin
      end
    endcase
    r.included_count = inc_total[k];
    return r;
  endfunction

  task automatic queue_word(input logic [2:0] cmd, input logic [9:0] opd,
                            input logic drain);
    queued_word_t q;
    q.drain = drain;
    q.word.command = cmd;
    q.word.operand = opd;
    cmd_queue = {cmd_queue, q};
    void'(step_set(GEN, q.word));
    n_queued++;
  endtask

  // Mostly moves that change the set, steered to grow or shrink it, with
  // out-of-range positions, no-change requests and raw noise mixed in.
  function automatic sis_in_t make_word(input bit grow);
    sis_in_t     w;
    int unsigned inc_n;
    int unsigned exc_n;
    int unsigned roll;
    int unsigned n;
    bit          want_in;
    inc_n = 32'(inc_total[GEN]);
    exc_n = UNIVERSE - inc_n;
    roll = $urandom_range(0, 99);
    want_in = grow ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
    if (inc_n == 0) want_in = 1'b1;
    if (exc_n == 0) want_in = 1'b0;
    n = want_in ? exc_n : inc_n;
    w.command = 3'($urandom_range(0, 7));
    w.operand = 10'($urandom_range(0, UNIVERSE - 1));
    if (roll < 80) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          w.command = want_in ? CMD_INC_POS : CMD_EXC_POS;
          case ($urandom_range(0, 3))
            0: w.operand = '0;
            1: w.operand = 10'(n - 1);
            default: w.operand = 10'($urandom_range(0, n - 1));
          endcase
        end
        2, 3: begin
          w.command = want_in ? CMD_INC_ELEM : CMD_EXC_ELEM;
          w.operand = want_in ? exc_list[GEN][10'($urandom_range(0, n - 1))]
                              : inc_list[GEN][10'($urandom_range(0, n - 1))];
        end
        default: w.command = CMD_QUERY;
      endcase
    end else if (roll < 90) begin
      // A position at or past the end of its list, unless that list holds every element.
      w.command = want_in ? CMD_INC_POS : CMD_EXC_POS;
      if (n < UNIVERSE) w.operand = 10'($urandom_range(n, UNIVERSE - 1));
    end else if (roll < 95 && inc_n != 0 && exc_n != 0) begin
      // Asks for the side that the element is already on.
      w.command = want_in ? CMD_EXC_ELEM : CMD_INC_ELEM;
      w.operand = want_in ? exc_list[GEN][10'($urandom_range(0, exc_n - 1))]
                          : inc_list[GEN][10'($urandom_range(0, inc_n - 1))];
    end
    return w;
  endfunction

  always @(negedge clk) begin
    if (word_taken) begin
      cmd_queue.delete(0);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                               : $urandom_range(0, 5);
      end
    end
    // A word already offered stays on the port until it is taken.
    if (!(start && !word_taken)) begin
      if (!stim_on || cmd_queue.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue[0].drain && awaited.size() != 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_item <= cmd_queue[0].word;
      end
    end
  end

  always @(posedge clk) begin
    word_taken = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result word: status %0d element %0d position %0d",
                     out_item.status, out_item.moved_element, out_item.new_position);
        end else begin
          want = awaited.pop_front();
          case (want.status)
            ST_DONE: n_done++;
            ST_SAME: n_same++;
            default: n_range++;
          endcase
          if (int'(want.included_count) > peak_count)
            peak_count = int'(want.included_count);
          if (out_item.status !== want.status ||
              out_item.moved_element !== want.moved_element ||
              out_item.new_position !== want.new_position ||
              out_item.is_member !== want.is_member ||
              out_item.included_count !== want.included_count) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch: expected status %0d element %0d position %0d member %0d count %0d",
                       want.status, want.moved_element, want.new_position,
                       want.is_member, want.included_count);
              $display("          got status %0d element %0d position %0d member %0d count %0d",
                       out_item.status, out_item.moved_element, out_item.new_position,
                       out_item.is_member, out_item.included_count);
            end
          end
        end
      end
      if (start && !busy) begin
        word_taken = 1'b1;
        awaited = {awaited, step_set(CHK, in_item)};
        n_taken++;
      end
      if (word_taken || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no word taken or returned for %0d cycles", IDLE_LIMIT);
        $display("sparse_index_set test failed");
        $finish;
      end
    end
  end

  initial begin
    sis_in_t w;
    bit      grow;
    int      phase_left;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < UNIVERSE; i++) begin
        inc_list[k][i] = '0;
        inc_where[k][i] = NOWHERE;
        exc_list[k][i] = i[9:0];
        exc_where[k][i] = i[10:0];
      end
      inc_total[k] = '0;
    end

    // Directed opening: empty and near-empty lists, both ends of each
    // list, repeated requests and the unused command codes.
    queue_word(CMD_EXC_POS, 10'd0, 1'b0);
    queue_word(CMD_QUERY, 10'd0, 1'b0);
    queue_word(CMD_QUERY, 10'd1023, 1'b0);
    queue_word(CMD_INC_ELEM, 10'd0, 1'b0);
    queue_word(CMD_INC_ELEM, 10'd0, 1'b0);
    queue_word(CMD_EXC_ELEM, 10'd5, 1'b0);
    queue_word(CMD_INC_POS, 10'd0, 1'b0);
    queue_word(CMD_INC_POS, 10'd1023, 1'b0);
    queue_word(CMD_INC_POS, 10'd1021, 1'b0);
    queue_word(CMD_INC_ELEM, 10'd1023, 1'b0);
    queue_word(CMD_QUERY, 10'd1023, 1'b0);
    queue_word(CMD_EXC_POS, 10'd1023, 1'b0);
    queue_word(CMD_EXC_POS, inc_total[GEN][9:0], 1'b0);
    queue_word(CMD_EXC_POS, 10'd0, 1'b0);
    queue_word(CMD_EXC_ELEM, 10'd0, 1'b0);
    queue_word(CMD_EXC_ELEM, 10'd1023, 1'b0);
    queue_word(CMD_RSVD5, 10'd1023, 1'b0);
    queue_word(CMD_RSVD6, 10'd0, 1'b0);
    queue_word(CMD_RSVD7, 10'd682, 1'b0);
    queue_word(CMD_INC_POS, 10'd0, 1'b1);
    queue_word(CMD_EXC_POS, inc_total[GEN][9:0] - 10'd1, 1'b0);
    queue_word(CMD_QUERY, 10'd341, 1'b0);

    grow = 1'b0;
    phase_left = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (phase_left == 0) begin
        grow = !grow;
        phase_left = $urandom_range(60, 200);
      end
      phase_left--;
      w = make_word(grow);
      queue_word(w.command, w.operand, (i % 250) == 249);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    stim_on <= 1'b1;

    while (n_taken != n_queued || awaited.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d command words: %0d done, %0d unchanged, %0d out of range or unknown",
             n_taken, n_done, n_same, n_range);
    $display("included set peaked at %0d elements; %0d mismatches", peak_count, n_errors);
    if (n_errors == 0) begin
      $display("sparse_index_set test passed");
    end else begin
      $display("sparse_index_set test failed");
    end
    $finish;
  end

endmodule
